[rtl/core/dqvd_pkg.sv]
// ----------------------------------------------------------------------------
// dqvd_pkg
// Shared sizes, codes and helpers for the double-ended queue block.
// ----------------------------------------------------------------------------
package dqvd_pkg;

	// store geometry
	localparam int DEPTH = 64;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int SUM_W = OCC_W + 1;

	// word field widths
	localparam int OP_W    = 4;
	localparam int VALUE_W = 32;
	localparam int CNT_W   = 8;
	localparam int STAT_W  = 2;

	// command codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_POP_FRONT  = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_CLEAR      = 4'd4,
		OP_DELETE     = 4'd5,
		OP_READ_ALL   = 4'd6,
		OP_READ_FIRST = 4'd7,
		OP_READ_LAST  = 4'd8
	} op_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_EMPTY_POP  = 2'd2,
		ST_EMPTY_READ = 2'd3
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DEL_RUN,
		S_RD_ISSUE,
		S_RD_EMIT
	} ctrl_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic    load_in;
		logic    push_front;
		logic    push_back;
		logic    pop_front;
		logic    pop_back;
		logic    clear;
		logic    del_start;
		logic    del_step;
		logic    del_finish;
		logic    rd_start;
		logic    rd_read;
		logic    rd_emit;
		logic    st_emit;
		status_t st_code;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic n_zero;
		logic del_busy;
		logic rd_last;
		logic out_free;
	} dp_stat_t;

	// ring slot of position pos counted from base
	function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
		input logic [OCC_W-1:0] pos);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(pos);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

[rtl/core/dqvd_if.sv]
// ----------------------------------------------------------------------------
// dqvd_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------

// command channel
interface dqvd_in_if import dqvd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic signed [VALUE_W-1:0] value;
	logic [CNT_W-1:0]   count;

	modport source (output valid, output op, output value, output count, input ready);
	modport sink   (input valid, input op, input value, input count, output ready);
endinterface

// result channel
interface dqvd_out_if import dqvd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [VALUE_W-1:0] item;
	logic               has_item;
	logic               last;
	logic [STAT_W-1:0]  status;

	modport source (output valid, output item, output has_item, output last,
		output status, input ready);
	modport sink   (input valid, input item, input has_item, input last,
		input status, output ready);
endinterface

[rtl/core/deque_with_value_delete.sv]
// ----------------------------------------------------------------------------
// deque_with_value_delete
// Bounded double-ended queue of signed 32-bit values with delete-by-value.
// ----------------------------------------------------------------------------
// One command word is taken at a time. Push, pop, clear and unknown commands
// are captured, then executed, and give one status word. Delete-value walks
// every held entry through the store, one entry a cycle, compacting survivors
// toward the head. Read commands give one word per entry (registered store
// read, then result load) after a start step, or a single empty word. The
// next command word is taken while the last result word still waits
// downstream. The store has no reset; only occupied slots are ever read.
module deque_with_value_delete import dqvd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dqvd_in_if.sink   req,
	dqvd_out_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	dqvd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// store and result datapath
	dqvd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_op    (req.op),
		.req_value (req.value),
		.req_count (req.count),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

[rtl/core/dqvd_ram.sv]
// ----------------------------------------------------------------------------
// dqvd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dqvd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/dqvd_datapath.sv]
// ----------------------------------------------------------------------------
// dqvd_datapath
// Ring pointers, entry store, delete compaction and result register.
// ----------------------------------------------------------------------------
module dqvd_datapath import dqvd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [OP_W-1:0]           req_op,
	input  logic signed [VALUE_W-1:0] req_value,
	input  logic [CNT_W-1:0]          req_count,
	input  dp_cmd_t                   cmd,
	output dp_stat_t                  stat,
	dqvd_out_if.source                rsp
);

	// captured command word
	op_t                      op_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]         cnt_q;

	// ring state and walk counters
	logic [IDX_W-1:0] head_q;
	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] i_q;
	logic [OCC_W-1:0] w_q;
	logic [OCC_W-1:0] n_q;
	logic             pend_q;

	// result register
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_item_q;
	logic                      out_has_q;
	logic                      out_last_q;
	status_t                   out_status_q;

	// store port signals
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;

	logic [OCC_W-1:0] n_rd;
	logic [OCC_W-1:0] rd_pos;
	logic [IDX_W-1:0] head_dec;
	logic [IDX_W-1:0] head_inc;
	logic             out_free;
	logic             del_more;
	logic             del_keep;

	dqvd_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// derived values
	always_comb begin
		head_dec = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
		head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
		if (op_q == OP_READ_ALL) begin
			n_rd = occ_q;
		end else if (cnt_q < CNT_W'(occ_q)) begin
			n_rd = OCC_W'(cnt_q);
		end else begin
			n_rd = occ_q;
		end
		rd_pos   = (op_q == OP_READ_LAST) ? OCC_W'(occ_q - OCC_W'(1) - i_q) : i_q;
		out_free = !out_valid_q || rsp.ready;
		del_more = (i_q < occ_q);
		del_keep = pend_q && (ram_rdata != value_q);
	end

	// store port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ring_slot(head_q, w_q);
		ram_wdata = value_q;
		ram_re    = 1'b0;
		ram_raddr = ring_slot(head_q, i_q);
		if (cmd.push_front) begin
			ram_we    = 1'b1;
			ram_waddr = head_dec;
		end else if (cmd.push_back) begin
			ram_we    = 1'b1;
			ram_waddr = ring_slot(head_q, occ_q);
		end else if (cmd.del_step) begin
			ram_we    = del_keep;
			ram_wdata = ram_rdata;
			ram_re    = del_more;
		end else if (cmd.rd_read) begin
			ram_re    = 1'b1;
			ram_raddr = ring_slot(head_q, rd_pos);
		end
	end

	// command word capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= op_t'(req_op);
			value_q <= req_value;
			cnt_q   <= req_count;
		end
	end

	// ring pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (cmd.push_front) begin
			head_q <= head_dec;
			occ_q  <= occ_q + OCC_W'(1);
		end else if (cmd.push_back) begin
			occ_q  <= occ_q + OCC_W'(1);
		end else if (cmd.pop_front) begin
			head_q <= head_inc;
			occ_q  <= occ_q - OCC_W'(1);
		end else if (cmd.pop_back) begin
			occ_q  <= occ_q - OCC_W'(1);
		end else if (cmd.clear) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (cmd.del_finish) begin
			occ_q  <= w_q;
		end
	end

	// walk counters for delete and reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			w_q    <= '0;
			n_q    <= '0;
			pend_q <= 1'b0;
		end else if (cmd.del_start) begin
			i_q    <= '0;
			w_q    <= '0;
			pend_q <= 1'b0;
		end else if (cmd.del_step) begin
			if (del_keep) begin
				w_q <= w_q + OCC_W'(1);
			end
			if (del_more) begin
				i_q <= i_q + OCC_W'(1);
			end
			pend_q <= del_more;
		end else if (cmd.rd_start) begin
			i_q <= '0;
			n_q <= n_rd;
		end else if (cmd.rd_read) begin
			i_q <= i_q + OCC_W'(1);
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rd_emit || cmd.st_emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.rd_emit) begin
			out_item_q   <= ram_rdata;
			out_has_q    <= 1'b1;
			out_last_q   <= (i_q == n_q);
			out_status_q <= ST_OK;
		end else if (cmd.st_emit) begin
			out_item_q   <= '0;
			out_has_q    <= 1'b0;
			out_last_q   <= 1'b1;
			out_status_q <= cmd.st_code;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.item     = out_item_q;
	assign rsp.has_item = out_has_q;
	assign rsp.last     = out_last_q;
	assign rsp.status   = out_status_q;

	// status toward the controller
	always_comb begin
		stat.op       = op_q;
		stat.full     = (occ_q == OCC_W'(DEPTH));
		stat.empty    = (occ_q == '0);
		stat.n_zero   = (n_rd == '0);
		stat.del_busy = del_more || pend_q;
		stat.rd_last  = (i_q == n_q);
		stat.out_free = out_free;
	end

`ifndef NO_ASSERTIONS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("occupancy above store depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= IDX_W'(DEPTH - 1))
		else $error("head index outside the ring");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.del_step || cmd.del_finish) |-> (w_q <= i_q))
		else $error("delete write position passed read position");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_emit || cmd.st_emit) |-> out_free)
		else $error("result loaded while result register busy");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del_finish |=> (occ_q <= $past(occ_q)))
		else $error("delete grew the occupancy");
`endif

endmodule

[rtl/core/dqvd_ctrl.sv]
// ----------------------------------------------------------------------------
// dqvd_ctrl
// Command sequencer: decodes each word and steps the datapath through it.
// ----------------------------------------------------------------------------
module dqvd_ctrl import dqvd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					priority case (stat.op)
						OP_DELETE: state_d = S_DEL_RUN;
						OP_READ_ALL, OP_READ_FIRST, OP_READ_LAST: begin
							state_d = stat.n_zero ? S_IDLE : S_RD_ISSUE;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_DEL_RUN: begin
				if (!stat.del_busy && stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_RD_ISSUE: state_d = S_RD_EMIT;
			S_RD_EMIT: begin
				if (stat.out_free) begin
					state_d = stat.rd_last ? S_IDLE : S_RD_ISSUE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		cmd.st_code = ST_OK;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_EXEC: begin
				if (stat.out_free) begin
					priority case (stat.op)
						OP_PUSH_FRONT: begin
							cmd.st_emit    = 1'b1;
							cmd.push_front = !stat.full;
							cmd.st_code    = stat.full ? ST_FULL : ST_OK;
						end
						OP_PUSH_BACK: begin
							cmd.st_emit   = 1'b1;
							cmd.push_back = !stat.full;
							cmd.st_code   = stat.full ? ST_FULL : ST_OK;
						end
						OP_POP_FRONT: begin
							cmd.st_emit   = 1'b1;
							cmd.pop_front = !stat.empty;
							cmd.st_code   = stat.empty ? ST_EMPTY_POP : ST_OK;
						end
						OP_POP_BACK: begin
							cmd.st_emit  = 1'b1;
							cmd.pop_back = !stat.empty;
							cmd.st_code  = stat.empty ? ST_EMPTY_POP : ST_OK;
						end
						OP_CLEAR: begin
							cmd.st_emit = 1'b1;
							cmd.clear   = 1'b1;
						end
						OP_DELETE: begin
							cmd.del_start = 1'b1;
						end
						OP_READ_ALL: begin
							cmd.st_emit  = stat.n_zero;
							cmd.st_code  = ST_EMPTY_READ;
							cmd.rd_start = !stat.n_zero;
						end
						OP_READ_FIRST, OP_READ_LAST: begin
							cmd.st_emit  = stat.n_zero;
							cmd.rd_start = !stat.n_zero;
						end
						default: begin
							cmd.st_emit = 1'b1;
						end
					endcase
				end
			end
			S_DEL_RUN: begin
				if (stat.del_busy) begin
					cmd.del_step = 1'b1;
				end else if (stat.out_free) begin
					cmd.del_finish = 1'b1;
					cmd.st_emit    = 1'b1;
				end
			end
			S_RD_ISSUE: begin
				cmd.rd_read = 1'b1;
			end
			S_RD_EMIT: begin
				cmd.rd_emit = stat.out_free;
			end
			default: begin
				cmd.st_code = ST_OK;
			end
		endcase
	end

endmodule
